FILE: rtl/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
package pba_pkg;

	// The page map is stored and scanned one word at a time.
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;
	// Width of page counts and page indexes derived from the 23-bit size and 32-bit address.
	localparam int PG_W      = 24;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_NORUN = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// One request beat.
	typedef struct packed {
		opcode_t     opcode;
		logic [22:0] size_bytes;
		logic [31:0] address;
	} req_t;

	// One response beat.
	typedef struct packed {
		logic [31:0] result_address;
		status_t     status;
	} rsp_t;

	// Bit bounds of the page span that falls inside the current word.
	typedef struct packed {
		logic [BIT_W-1:0] lo_bit;
		logic [BIT_W-1:0] hi_bit;
	} span_t;

	// First position in the word where a long enough free run ends.
	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] pos;
	} hit_t;

endpackage

FILE: rtl/pba_map_ram.sv
// Page map storage: one write port and one registered read port.
module pba_map_ram import pba_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	// Write and read in the same clocked block; read data is registered and appears in the cycle after the read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/pba_word_unit.sv
// Shared word evaluator: free-run detection for the scan and span masks for updates.
module pba_word_unit import pba_pkg::*; #(
	parameter int RW = 11
) (
	input  logic [WORD_BITS-1:0] used,
	input  logic [WORD_BITS-1:0] present,
	input  logic [RW-1:0]        carry_in,
	input  logic [RW-1:0]        need,
	input  span_t                span,
	output hit_t                 hit,
	output logic [RW-1:0]        carry_out,
	output logic [WORD_BITS-1:0] span_mask
);

	logic [WORD_BITS-1:0] all_v;
	logic [BIT_W:0]       len_v [WORD_BITS];
	logic [RW-1:0]        run_v [WORD_BITS];
	logic [WORD_BITS-1:0] hit_v;
	logic [WORD_BITS-1:0] first_v;
	logic [BIT_W-1:0]     pos_v;

	// Prefix scan of free-run length ending at each bit, in log2(WORD_BITS) levels.
	// A segment that is entirely free extends the run of the segment below it.
	always_comb begin
		all_v = present & ~used;
		for (int j = 0; j < WORD_BITS; j++) begin
			len_v[j] = (BIT_W+1)'(all_v[j]);
		end
		for (int d = 1; d < WORD_BITS; d = d * 2) begin
			for (int j = WORD_BITS - 1; j >= d; j--) begin
				if (all_v[j]) begin
					len_v[j] = len_v[j] + len_v[j-d];
					all_v[j] = all_v[j-d];
				end
			end
		end
		for (int j = 0; j < WORD_BITS; j++) begin
			run_v[j] = all_v[j] ? carry_in + RW'(len_v[j]) : RW'(len_v[j]);
			hit_v[j] = (run_v[j] >= need);
		end
	end

	// Lowest hit position: isolate the lowest set bit, then encode it.
	always_comb begin
		first_v = hit_v & (~hit_v + WORD_BITS'(1));
		pos_v   = '0;
		for (int b = 0; b < BIT_W; b++) begin
			for (int j = 0; j < WORD_BITS; j++) begin
				if (first_v[j] && ((j >> b) % 2 == 1)) begin
					pos_v[b] = 1'b1;
				end
			end
		end
	end

	assign hit.hit   = |hit_v;
	assign hit.pos   = pos_v;
	assign carry_out = run_v[WORD_BITS-1];

	// Mask of bits lo_bit through hi_bit inclusive.
	assign span_mask = ({WORD_BITS{1'b1}} << span.lo_bit) & ({WORD_BITS{1'b1}} >> ~span.hi_bit);

endmodule

FILE: rtl/page_bitmap_allocator_core.sv
// Page bitmap allocator core: first-fit contiguous page allocation over a one-bit-per-page map.
//
// The map holds one bit per page in 32-bit words and is walked one word per cycle through a
// single memory port, so the word count sets the timing. After reset a clearing pass writes
// every word to zero, during which no request is taken. An allocate prepares, scans the words
// up to the word where the first fitting run ends, locates the run and then rewrites the words
// that run spans. A rejected allocate (zero size, too large, or no run) ends after the
// preparation or the full scan. A free prepares and then rewrites the words its page range
// spans inside the map.
// One request is in flight at a time; a finished response may wait in the output register
// while the next request is accepted.
module page_bitmap_allocator_core import pba_pkg::*; #(
	parameter int MAP_PAGES       = 1024,
	parameter int PAGE_SHIFT_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp
);

	localparam int WORDS     = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int RW        = WA_W + BIT_W + 1;
	localparam int LAST_BITS = MAP_PAGES - (WORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
	localparam logic [PG_W-1:0] PAGE_ROUND = PG_W'((1 << PAGE_SHIFT_BITS) - 1);
	localparam logic [PG_W-1:0] MAP_PG     = PG_W'(MAP_PAGES);
	localparam logic [PG_W:0]   MAP_END    = (PG_W+1)'(MAP_PAGES);
	localparam logic [RW-1:0]   MAP_RW     = RW'(MAP_PAGES);
	localparam logic [WA_W-1:0] LAST_WORD  = WA_W'(WORDS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP1,
		S_PREP2,
		S_SCAN,
		S_LOCATE,
		S_UPDATE,
		S_FIN
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic [31:0]       base_q;
	logic [PG_W-1:0]   pages_q;
	logic [PG_W-1:0]   first_q;
	logic [RW-1:0]     need_q;
	logic [RW-1:0]     carry_q;
	logic [WA_W-1:0]   ra_q;
	logic              ra_done_q;
	logic              rv_s1;
	logic [WA_W-1:0]   wa_s1;
	logic [RW-1:0]     lo_q;
	logic [RW-1:0]     hi_m1_q;
	status_t           status_q;
	logic              addr_ok_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic                 rd_en;
	logic                 ram_we;
	logic [WA_W-1:0]      ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] present;
	logic [WORD_BITS-1:0] span_mask;
	logic [WA_W-1:0]      lo_w;
	logic [WA_W-1:0]      hi_w;
	logic [WA_W-1:0]      ra_last;
	span_t                span;
	hit_t                 hit;
	logic [RW-1:0]        carry_out;
	logic [RW-1:0]        hit_end;
	logic [RW-1:0]        lo_next;
	logic [PG_W:0]        end_full;
	logic [RW-1:0]        hi_clamp;

	// Base address register; the user must write it only while the block is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// Word addresses of the first and last page of the span being updated.
	assign lo_w    = lo_q[BIT_W+WA_W-1:BIT_W];
	assign hi_w    = hi_m1_q[BIT_W+WA_W-1:BIT_W];
	assign ra_last = (state_q == S_SCAN) ? LAST_WORD : hi_w;

	// Map port control: reads stream one word per cycle, each word is written back in the cycle after its read.
	assign rd_en     = (state_q == S_SCAN || state_q == S_UPDATE) && !ra_done_q;
	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_UPDATE && rv_s1);
	assign ram_waddr = (state_q == S_CLEAR) ? ra_q : wa_s1;
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_wdata = '0;
		end else if (req_q.opcode == OP_ALLOC) begin
			ram_wdata = rd_data | span_mask;
		end else begin
			ram_wdata = rd_data & ~span_mask;
		end
	end

	pba_map_ram #(
		.DEPTH (WORDS),
		.AW    (WA_W)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (ra_q),
		.rdata (rd_data)
	);

	// Inputs of the shared word evaluator for the word now returned from the map.
	assign present     = (wa_s1 == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}};
	assign span.lo_bit = (wa_s1 == lo_w) ? lo_q[BIT_W-1:0] : '0;
	assign span.hi_bit = (wa_s1 == hi_w) ? hi_m1_q[BIT_W-1:0] : '1;

	pba_word_unit #(
		.RW (RW)
	) u_unit (
		.used      (rd_data),
		.present   (present),
		.carry_in  (carry_q),
		.need      (need_q),
		.span      (span),
		.hit       (hit),
		.carry_out (carry_out),
		.span_mask (span_mask)
	);

	// Index arithmetic for locating a run and clamping a free range to the map.
	assign hit_end  = {1'b0, wa_s1, hit.pos};
	assign lo_next  = hi_m1_q + RW'(1) - need_q;
	assign end_full = {1'b0, first_q} + {1'b0, pages_q};
	assign hi_clamp = (end_full >= MAP_END) ? MAP_RW : RW'(end_full);

	assign req_stall = (state_q != S_IDLE);

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			req_q       <= '0;
			pages_q     <= '0;
			first_q     <= '0;
			need_q      <= '0;
			carry_q     <= '0;
			ra_q        <= '0;
			ra_done_q   <= 1'b0;
			rv_s1       <= 1'b0;
			wa_s1       <= '0;
			lo_q        <= '0;
			hi_m1_q     <= '0;
			status_q    <= ST_OK;
			addr_ok_q   <= 1'b0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			wa_s1 <= ra_q;
			if (rd_en) begin
				ra_q      <= ra_q + WA_W'(1);
				ra_done_q <= (ra_q == ra_last);
			end
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					ra_q <= ra_q + WA_W'(1);
					if (ra_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_PREP1;
					end
				end
				// Page count and, for a free, the first page index.
				S_PREP1: begin
					if (req_q.opcode == OP_ALLOC) begin
						pages_q <= ({1'b0, req_q.size_bytes} + PAGE_ROUND) >> PAGE_SHIFT_BITS;
					end else begin
						pages_q <= PG_W'(req_q.size_bytes >> PAGE_SHIFT_BITS);
					end
					first_q <= PG_W'((req_q.address - base_q) >> PAGE_SHIFT_BITS);
					state_q <= S_PREP2;
				end
				// Reject or set up the scan (allocate) or the clear span (free).
				S_PREP2: begin
					status_q  <= ST_OK;
					addr_ok_q <= 1'b0;
					carry_q   <= '0;
					ra_done_q <= 1'b0;
					if (req_q.opcode == OP_ALLOC) begin
						ra_q <= '0;
						if (pages_q == '0) begin
							status_q <= ST_ZERO;
							state_q  <= S_FIN;
						end else if (pages_q > MAP_PG) begin
							status_q <= ST_NORUN;
							state_q  <= S_FIN;
						end else begin
							need_q  <= RW'(pages_q);
							state_q <= S_SCAN;
						end
					end else begin
						if (pages_q != '0 && end_full > MAP_END) begin
							status_q <= ST_RANGE;
						end
						lo_q    <= RW'(first_q);
						hi_m1_q <= hi_clamp - RW'(1);
						ra_q    <= first_q[BIT_W+WA_W-1:BIT_W];
						if (pages_q != '0 && first_q < MAP_PG) begin
							state_q <= S_UPDATE;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				// First-fit scan, carrying the free run across word boundaries.
				S_SCAN: begin
					if (rv_s1) begin
						carry_q <= carry_out;
						if (hit.hit) begin
							hi_m1_q <= hit_end;
							state_q <= S_LOCATE;
						end else if (wa_s1 == LAST_WORD) begin
							status_q <= ST_NORUN;
							state_q  <= S_FIN;
						end
					end
				end
				S_LOCATE: begin
					lo_q      <= lo_next;
					ra_q      <= lo_next[BIT_W+WA_W-1:BIT_W];
					ra_done_q <= 1'b0;
					state_q   <= S_UPDATE;
				end
				// Read-modify-write of every word that the span touches.
				S_UPDATE: begin
					if (rv_s1 && wa_s1 == hi_w) begin
						addr_ok_q <= (req_q.opcode == OP_ALLOC);
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.result_address <= addr_ok_q ?
							base_q + (32'(lo_q) << PAGE_SHIFT_BITS) : '0;
						rsp_q.status <= status_q;
						rsp_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The write-back of one word never collides with the read of the next.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && rd_en) |-> (ram_waddr != ra_q))
		else $error("map write and read hit the same word");

	// A scan always looks for a run that can fit in the map.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (need_q != '0 && need_q <= MAP_RW))
		else $error("scan run length out of bounds");

	// An update span is ordered and lies inside the map.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) |-> (lo_q <= hi_m1_q && hi_m1_q < MAP_RW))
		else $error("update span outside the map");

	// Only a successful allocate may report a nonzero address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |-> (rsp.result_address == '0))
		else $error("failed request reports an address");

endmodule
